/* sv/dep_pkg.sv */
// Shared types and codes for the directory entry parser.
package dep_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REASON_SIZE        = 2'd0,
        REASON_ZERO_TYPE   = 2'd1,
        REASON_BLOCK_LIMIT = 2'd2,
        REASON_BAD_LENGTH  = 2'd3
    } end_reason_t;

    // configuration register indexes
    localparam logic [1:0] CFG_DIR_SIZE        = 2'd0;
    localparam logic [1:0] CFG_BLOCK_SIZE_CODE = 2'd1;

    localparam int HEADER_BYTES = 8;
    localparam int OUT_TDATA_W  = 88;

    typedef struct packed {
        logic [15:0] dir_offset;
        logic [15:0] record_pos;
        logic [63:0] header_bytes;
        logic        parse_stopped;
        logic        entry_live;
    } parse_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] entry_offset;
        logic [31:0] entry_inode;
        logic [15:0] record_length;
        logic [7:0]  name_length;
        logic [7:0]  name_byte;
        logic        last_name_byte;
        end_reason_t end_reason;
    } parse_result_t;

endpackage

/* sv/dep_step.sv */
// Per-byte parse step: next parser state and the optional result for one byte.
module dep_step #(
    parameter int MAX_DIRECT_BLOCKS = 12
) (
    input  dep_pkg::parse_state_t  state_in,
    input  logic [7:0]             dir_byte,
    input  logic                   first_byte,
    input  logic [15:0]            dir_size,
    input  logic [1:0]             block_size_code,
    output dep_pkg::parse_state_t  state_next,
    output logic                   emit,
    output dep_pkg::parse_result_t result
);

    localparam int LimitW = $clog2(MAX_DIRECT_BLOCKS + 1) + 16;

    dep_pkg::parse_state_t cur;
    logic [63:0]       hdr_new;
    logic [63:0]       hdr_sel;
    logic [LimitW-1:0] limit;
    logic [16:0]       pos_inc;
    logic [16:0]       off_sum;
    logic [15:0]       off_sat;
    logic [15:0]       name_pos;
    logic              at_start;
    logic              in_header;
    logic              at_type;

    always_comb begin
        cur = state_in;
        if (first_byte) begin
            cur.dir_offset    = '0;
            cur.record_pos    = '0;
            cur.header_bytes  = '0;
            cur.entry_live    = 1'b0;
            cur.parse_stopped = 1'b0;
        end

        // merge the byte into its header lane
        hdr_new = cur.header_bytes;
        for (int i = 0; i < dep_pkg::HEADER_BYTES; i++) begin
            if (cur.record_pos[2:0] == 3'(i)) begin
                hdr_new[8*i +: 8] = dir_byte;
            end
        end

        at_start  = (cur.record_pos == 16'd0);
        in_header = (cur.record_pos < 16'(dep_pkg::HEADER_BYTES));
        at_type   = (cur.record_pos == 16'(dep_pkg::HEADER_BYTES - 1));
        hdr_sel   = in_header ? hdr_new : cur.header_bytes;

        limit    = LimitW'(MAX_DIRECT_BLOCKS) << (4'd10 + {2'b00, block_size_code});
        pos_inc  = {1'b0, cur.record_pos} + 17'd1;
        off_sum  = {1'b0, cur.dir_offset} + {1'b0, hdr_sel[47:32]};
        off_sat  = off_sum[16] ? 16'hFFFF : off_sum[15:0];
        name_pos = cur.record_pos - 16'(dep_pkg::HEADER_BYTES);

        state_next = cur;
        emit       = 1'b0;

        result.kind           = dep_pkg::KIND_HEADER;
        result.entry_offset   = cur.dir_offset;
        result.entry_inode    = cur.header_bytes[31:0];
        result.record_length  = cur.header_bytes[47:32];
        result.name_length    = cur.header_bytes[55:48];
        result.name_byte      = 8'd0;
        result.last_name_byte = 1'b0;
        result.end_reason     = dep_pkg::REASON_SIZE;

        if (!cur.parse_stopped) begin
            if (at_start && (cur.dir_offset >= dir_size)) begin
                emit                     = 1'b1;
                result.kind              = dep_pkg::KIND_END;
                result.end_reason        = dep_pkg::REASON_SIZE;
                state_next.parse_stopped = 1'b1;
                state_next.entry_live    = 1'b0;
            end else if (at_start && (LimitW'(cur.dir_offset) >= limit)) begin
                emit                     = 1'b1;
                result.kind              = dep_pkg::KIND_END;
                result.end_reason        = dep_pkg::REASON_BLOCK_LIMIT;
                state_next.parse_stopped = 1'b1;
                state_next.entry_live    = 1'b0;
            end else if (in_header) begin
                state_next.header_bytes = hdr_new;
                result.entry_inode      = hdr_new[31:0];
                result.record_length    = hdr_new[47:32];
                result.name_length      = hdr_new[55:48];
                if (at_type && (hdr_new[63:56] == 8'd0)) begin
                    emit                     = 1'b1;
                    result.kind              = dep_pkg::KIND_END;
                    result.end_reason        = dep_pkg::REASON_ZERO_TYPE;
                    state_next.parse_stopped = 1'b1;
                    state_next.entry_live    = 1'b0;
                end else if (at_type && (hdr_new[47:32] < 16'(dep_pkg::HEADER_BYTES))) begin
                    emit                     = 1'b1;
                    result.kind              = dep_pkg::KIND_END;
                    result.end_reason        = dep_pkg::REASON_BAD_LENGTH;
                    state_next.parse_stopped = 1'b1;
                    state_next.entry_live    = 1'b0;
                end else begin
                    if (at_type && (hdr_new[31:0] != 32'd0)) begin
                        emit                  = 1'b1;
                        state_next.entry_live = 1'b1;
                    end
                    state_next.record_pos = pos_inc[15:0];
                    // header-only record: advance to the next one right away
                    if (at_type && (hdr_new[47:32] == 16'(dep_pkg::HEADER_BYTES))) begin
                        state_next.dir_offset   = off_sat;
                        state_next.record_pos   = '0;
                        state_next.header_bytes = '0;
                        state_next.entry_live   = 1'b0;
                    end
                end
            end else begin
                if (cur.entry_live && (name_pos < {8'd0, cur.header_bytes[55:48]})) begin
                    emit                  = 1'b1;
                    result.kind           = dep_pkg::KIND_NAME;
                    result.name_byte      = dir_byte;
                    result.last_name_byte =
                        ((name_pos + 16'd1) == {8'd0, cur.header_bytes[55:48]}) ||
                        (pos_inc >= {1'b0, cur.header_bytes[47:32]});
                end
                state_next.record_pos = pos_inc[15:0];
                if (pos_inc >= {1'b0, cur.header_bytes[47:32]}) begin
                    state_next.dir_offset   = off_sat;
                    state_next.record_pos   = '0;
                    state_next.header_bytes = '0;
                    state_next.entry_live   = 1'b0;
                end
            end
        end
    end

endmodule

/* sv/directory_entry_parser_top.sv */
// Top level of the directory entry parser: handshakes, registers and config.
//
//  Channel  | Direction | Beat payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: dir_byte; tuser: first_byte
//  m_axis   | out       | tdata: offset/inode/lengths/name byte/reason; tuser: kind;
//           |           | tlast: last_name_byte
//  cfg      | in        | cfg_index selects dir_size (0) or block_size_code (1)
//
// One directory byte per cycle while results are taken; each byte is held in the input
// register, and the parse step writes its result into the result register.
// aresetn is synchronous and active low; it leaves the parser stopped until a
// byte with first_byte set arrives, and clears dir_size and block_size_code.
// A result not taken downstream holds the result register and, behind it, the
// input register; bytes that give no result still wait for a free result slot.
// cfg_ready is always high; write only while the parser is idle.
module directory_entry_parser_top #(
    parameter int MAX_DIRECT_BLOCKS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] dir_byte
    input  logic                            s_axis_tuser,  // [0] first_byte
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] entry_offset, [47:16] entry_inode, [63:48] record_length,
    // [71:64] name_length, [79:72] name_byte, [81:80] end_reason, [87:82] zero
    output logic [dep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                      m_axis_tuser,  // [1:0] kind
    output logic                            m_axis_tlast,  // last_name_byte
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    // configuration registers
    logic [15:0] dir_size_reg;
    logic [1:0]  block_code_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;

    // parser state
    dep_pkg::parse_state_t state_reg, state_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    dep_pkg::parse_result_t out_reg;

    dep_pkg::parse_result_t step_result;
    logic                   step_emit;
    logic                   advance;
    logic                   in_take;

    dep_step #(
        .MAX_DIRECT_BLOCKS (MAX_DIRECT_BLOCKS)
    ) u_step (
        .state_in        (state_reg),
        .dir_byte        (in_byte_reg),
        .first_byte      (in_first_reg),
        .dir_size        (dir_size_reg),
        .block_size_code (block_code_reg),
        .state_next      (state_next),
        .emit            (step_emit),
        .result          (step_result)
    );

    // advance the held byte when the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb begin
        in_valid_next = in_take ? 1'b1 : (in_valid_reg && !advance);
        if (advance) begin
            out_valid_next = step_emit;
        end else begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
        if (advance && step_emit) begin
            out_reg <= step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.dir_offset    <= '0;
            state_reg.record_pos    <= '0;
            state_reg.header_bytes  <= '0;
            state_reg.parse_stopped <= 1'b1;
            state_reg.entry_live    <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // drop writes to indexes beyond the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_size_reg   <= '0;
            block_code_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                dep_pkg::CFG_DIR_SIZE:        dir_size_reg   <= cfg_data;
                dep_pkg::CFG_BLOCK_SIZE_CODE: block_code_reg <= cfg_data[1:0];
                default:                      ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last_name_byte;
    assign m_axis_tdata  = {6'd0, out_reg.end_reason, out_reg.name_byte, out_reg.name_length,
                            out_reg.record_length, out_reg.entry_inode, out_reg.entry_offset};

endmodule

/* sv/dep_checker.sv */
// Port-level assertions for the directory entry parser, bound to the top level.
module dep_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [dep_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                      m_axis_tuser,
    input logic                            m_axis_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    a_last_on_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != dep_pkg::KIND_NAME) |-> !m_axis_tlast)
        else $error("tlast on a non-name result");

    a_reason_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != dep_pkg::KIND_END) |-> m_axis_tdata[81:80] == 2'd0)
        else $error("end reason set on a non-end result");

    a_byte_on_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != dep_pkg::KIND_NAME) |-> m_axis_tdata[79:72] == 8'd0)
        else $error("name byte set on a non-name result");

endmodule

bind directory_entry_parser_top dep_checker u_dep_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
